### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for writing clocked concurrent assertions with a reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/irsr_pkg.sv
// ----------------------------------------------------------------------------
// irsr_pkg
// Types, constants and helper functions for the int8 stochastic requantizer.
// ----------------------------------------------------------------------------
package irsr_pkg;

    // Field widths.
    localparam int GRAD_W  = 32;
    localparam int SCALE_W = 5;
    localparam int LFSR_W  = 8;
    localparam int QUANT_W = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LFSR_SEED    = 2'd2;

    // Reset values.
    localparam logic [LFSR_W-1:0]  LFSR_RESET  = 8'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd0;

    // Fixed rescale offset: one extra fractional bit on top of the byte drop.
    localparam logic [6:0] SHIFT_OFFSET = 7'd9;

    // Saturation limits of the int8 result.
    localparam logic signed [QUANT_W-1:0] Q_MAX = 8'sd127;
    localparam logic signed [QUANT_W-1:0] Q_MIN = -8'sd128;

    // Sticky-flag events reported by the rounding logic.
    typedef struct packed {
        logic c9_ovf;   // coarse candidate left the int8 range
        logic c8_ovf;   // finer candidate left the int8 range
    } t_round_status;

    // One step of the 8-bit LFSR, taps 7, 5, 4 and 3, shifting left.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
        logic fb;
        fb = cur[7] ^ cur[5] ^ cur[4] ^ cur[3];
        return {cur[LFSR_W-2:0], fb};
    endfunction

endpackage

### hw/rtl/int8_requantize_stochastic_round_unit.sv
// ----------------------------------------------------------------------------
// int8_requantize_stochastic_round_unit
// Streaming requantizer from signed 32-bit values to int8 with LFSR rounding.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle, as long as the output side accepts,
// and returns one result per item, in order; each item passes through the input
// register and then the result register, with the rescale shift and both
// rounding steps done between them. The result register frees itself
// whenever its item is taken, so the input side keeps flowing as long as the
// output side accepts. The scales and the seed may only be written while no
// item is in flight; writing the seed restarts the rounding sequence from it.
module int8_requantize_stochastic_round_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] grad_value
    input  logic [0:0]  s_tuser,    // [0] restart_flags
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] quant_value
    output logic [1:0]  m_tuser,    // [0] overflow_seen, [1] fits_finer
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [irsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import irsr_pkg::*;

    // Configuration and rounding state.
    logic [SCALE_W-1:0] r_source_scale, n_source_scale;
    logic [SCALE_W-1:0] r_target_scale, n_target_scale;
    logic [LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic               r_ovf_flag, n_ovf_flag;
    logic               r_finer_flag, n_finer_flag;

    // Input register.
    logic               r_s1_valid, n_s1_valid;
    logic [GRAD_W-1:0]  r_s1_grad;
    logic               r_s1_restart;

    // Result register.
    logic               r_m_valid, n_m_valid;
    logic [QUANT_W-1:0] r_m_quant;
    logic               r_m_ovf;
    logic               r_m_finer;

    logic               s_accept;
    logic               s1_adv;
    logic               cfg_write;
    logic [GRAD_W-1:0]  scaled;
    logic [LFSR_W-1:0]  lfsr_after;
    logic [QUANT_W-1:0] quant;
    t_round_status      status;
    logic               ovf_base;
    logic               finer_base;

    // Handshakes: the input register moves on whenever the result register is free.
    assign s1_adv      = r_s1_valid && (!r_m_valid || m_tready);
    assign s_tready    = i_rst_n && (!r_s1_valid || s1_adv);
    assign s_accept    = s_tvalid && s_tready;
    assign o_cfg_ready = i_rst_n;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_quant;
    assign m_tuser  = {r_m_finer, r_m_ovf};

    // Rescale and round the item held in the input register.
    irsr_shift u_shift (
        .i_grad         (r_s1_grad),
        .i_source_scale (r_source_scale),
        .i_target_scale (r_target_scale),
        .o_scaled       (scaled)
    );

    irsr_round u_round (
        .i_scaled    (scaled),
        .i_lfsr      (r_lfsr),
        .o_lfsr_next (lfsr_after),
        .o_quant     (quant),
        .o_status    (status)
    );

    // Sticky flags restart before the item when asked to.
    assign ovf_base   = r_s1_restart ? 1'b0 : r_ovf_flag;
    assign finer_base = r_s1_restart ? 1'b1 : r_finer_flag;

    // Next state of configuration, LFSR and flags.
    always_comb begin
        n_source_scale = r_source_scale;
        n_target_scale = r_target_scale;
        n_lfsr         = r_lfsr;
        n_ovf_flag     = r_ovf_flag;
        n_finer_flag   = r_finer_flag;
        if (s1_adv) begin
            n_lfsr       = lfsr_after;
            n_ovf_flag   = ovf_base | status.c9_ovf;
            n_finer_flag = finer_base & ~status.c8_ovf;
        end
        if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_SOURCE_SCALE: n_source_scale = i_cfg_data[SCALE_W-1:0];
                CFG_TARGET_SCALE: n_target_scale = i_cfg_data[SCALE_W-1:0];
                CFG_LFSR_SEED:    n_lfsr         = i_cfg_data;
                default:          n_lfsr         = n_lfsr;
            endcase
        end
    end

    // Valid bits of the two registers.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_m_valid = r_m_valid;
        if (s1_adv) begin
            n_m_valid = 1'b1;
        end else if (m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_scale <= SCALE_RESET;
            r_target_scale <= SCALE_RESET;
            r_lfsr         <= LFSR_RESET;
            r_ovf_flag     <= 1'b0;
            r_finer_flag   <= 1'b1;
            r_s1_valid     <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            r_source_scale <= n_source_scale;
            r_target_scale <= n_target_scale;
            r_lfsr         <= n_lfsr;
            r_ovf_flag     <= n_ovf_flag;
            r_finer_flag   <= n_finer_flag;
            r_s1_valid     <= n_s1_valid;
            r_m_valid      <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_grad    <= s_tdata;
            r_s1_restart <= s_tuser[0];
        end
        if (s1_adv) begin
            r_m_quant <= quant;
            r_m_ovf   <= n_ovf_flag;
            r_m_finer <= n_finer_flag;
        end
    end

endmodule

### hw/rtl/irsr_shift.sv
// ----------------------------------------------------------------------------
// irsr_shift
// Rescales the incoming value by target_scale + 9 - source_scale positions.
// ----------------------------------------------------------------------------
module irsr_shift (
    input  logic [irsr_pkg::GRAD_W-1:0]  i_grad,
    input  logic [irsr_pkg::SCALE_W-1:0] i_source_scale,
    input  logic [irsr_pkg::SCALE_W-1:0] i_target_scale,
    output logic [irsr_pkg::GRAD_W-1:0]  o_scaled
);
    import irsr_pkg::*;

    logic signed [6:0]         shift_dist;
    logic [SCALE_W-1:0]        right_amt;
    logic signed [GRAD_W-1:0]  grad_s;
    logic [6:0]                neg_dist;

    // Signed distance; positive means a left shift.
    assign shift_dist = $signed({2'b00, i_target_scale} + SHIFT_OFFSET
                                - {2'b00, i_source_scale});
    assign neg_dist   = 7'(-shift_dist);
    assign right_amt  = neg_dist[SCALE_W-1:0];
    assign grad_s     = $signed(i_grad);

    // Left shift keeps the low word and empties out past 31; right shift is arithmetic.
    always_comb begin
        if (shift_dist > 7'sd0) begin
            if (shift_dist >= 7'sd32) begin
                o_scaled = '0;
            end else begin
                o_scaled = i_grad << shift_dist[SCALE_W-1:0];
            end
        end else begin
            o_scaled = GRAD_W'(grad_s >>> right_amt);
        end
    end

endmodule

### hw/rtl/irsr_round.sv
// ----------------------------------------------------------------------------
// irsr_round
// Forms the two stochastically rounded candidates and saturates the result.
// ----------------------------------------------------------------------------
module irsr_round (
    input  logic [irsr_pkg::GRAD_W-1:0]  i_scaled,
    input  logic [irsr_pkg::LFSR_W-1:0]  i_lfsr,
    output logic [irsr_pkg::LFSR_W-1:0]  o_lfsr_next,
    output logic [irsr_pkg::QUANT_W-1:0] o_quant,
    output irsr_pkg::t_round_status      o_status
);
    import irsr_pkg::*;

    logic [LFSR_W-1:0]  rnd_a;
    logic [LFSR_W-1:0]  rnd_b;
    logic               up8;
    logic               up9;
    logic signed [24:0] c8;
    logic signed [23:0] c9;

    // The LFSR steps once for each candidate.
    assign rnd_a       = lfsr_step(i_lfsr);
    assign rnd_b       = lfsr_step(rnd_a);
    assign o_lfsr_next = rnd_b;

    // Round up when the dropped byte exceeds the random byte.
    assign up8 = i_scaled[7:0] > rnd_a;
    assign up9 = i_scaled[8:1] > rnd_b;

    // Floor division by 256 and 512 of the signed word, plus the round-up bit.
    assign c8 = $signed({i_scaled[GRAD_W-1], i_scaled[GRAD_W-1:8]}) + $signed({24'd0, up8});
    assign c9 = $signed({i_scaled[GRAD_W-1], i_scaled[GRAD_W-1:9]}) + $signed({23'd0, up9});

    // Range checks against the int8 limits.
    assign o_status.c8_ovf = (c8 > 25'(Q_MAX)) || (c8 < 25'(Q_MIN));
    assign o_status.c9_ovf = (c9 > 24'(Q_MAX)) || (c9 < 24'(Q_MIN));

    // Saturate the coarse candidate.
    always_comb begin
        if (c9 > 24'(Q_MAX)) begin
            o_quant = Q_MAX;
        end else if (c9 < 24'(Q_MIN)) begin
            o_quant = Q_MIN;
        end else begin
            o_quant = c9[QUANT_W-1:0];
        end
    end

endmodule

### hw/rtl/irsr_chk.sv
// ----------------------------------------------------------------------------
// irsr_chk
// Port-level checks for the int8 stochastic requantizer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irsr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result item holds its payload.
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A coarse overflow always implies the finer candidate overflowed too.
    `ASSERT_CLK(a_flags_consistent, i_clk, i_rst_n, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "overflow_seen set while fits_finer still set")

    // A new result appears only for an item that was taken and passed through the input register.
    `ASSERT_CLK(a_result_origin, i_clk, i_rst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without a matching input item")

    // Nothing is taken while reset is held.
    `ASSERT_ALWAYS(a_no_take_in_reset, i_clk, !i_rst_n |-> !s_tready, "input ready during reset")

endmodule

bind int8_requantize_stochastic_round_unit irsr_chk u_irsr_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the int8 stochastic-rounding requantizer. Gradients
// stream in through the slave port, and a scoreboard predicts each int8 result
// and both sticky flags from its own copy of the scales and the LFSR. The run
// covers many scale and seed settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import irsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 185;
    localparam int HOLD_CYCLES    = 150;

    // No register sits at this index; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [QUANT_W-1:0] quant;
        logic               overflow;
        logic               finer;
    } quant_result_t;

    // Scoreboard: predicts each result and checks it against the block.
    class requant_scoreboard;
        logic [SCALE_W-1:0] src_scale;
        logic [SCALE_W-1:0] tgt_scale;
        logic [LFSR_W-1:0]  rng_state;
        logic               overflow_sticky;
        logic               finer_sticky;
        quant_result_t      quant_q[$];
        int                 failures;

        function new();
            src_scale       = '0;
            tgt_scale       = '0;
            rng_state       = 8'd1;
            overflow_sticky = 1'b0;
            finer_sticky    = 1'b1;
            failures        = 0;
        endfunction

        function automatic logic [LFSR_W-1:0] advance_rng(logic [LFSR_W-1:0] cur);
            return {cur[6:0], cur[7] ^ cur[5] ^ cur[4] ^ cur[3]};
        endfunction

        // A configuration write mirrors what the block keeps of it.
        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                CFG_SOURCE_SCALE: src_scale = data[SCALE_W-1:0];
                CFG_TARGET_SCALE: tgt_scale = data[SCALE_W-1:0];
                CFG_LFSR_SEED:    rng_state = data;
                default: ;
            endcase
        endfunction

        // Rescale, round twice with fresh LFSR values, saturate and update flags.
        function automatic quant_result_t requantize(logic [GRAD_W-1:0] grad, bit restart);
            int            shift;
            logic [31:0]   scaled;
            int            fine_cand;
            int            coarse_cand;
            quant_result_t res;
            if (restart) begin
                overflow_sticky = 1'b0;
                finer_sticky    = 1'b1;
            end
            shift = int'(tgt_scale) + 9 - int'(src_scale);
            if (shift >= 32) begin
                scaled = '0;
            end else if (shift > 0) begin
                scaled = grad << shift;
            end else begin
                scaled = $signed(grad) >>> (-shift);
            end
            rng_state = advance_rng(rng_state);
            fine_cand = int'($signed(scaled) >>> 8) + ((scaled[7:0] > rng_state) ? 1 : 0);
            rng_state = advance_rng(rng_state);
            coarse_cand = int'($signed(scaled) >>> 9) + ((scaled[8:1] > rng_state) ? 1 : 0);
            if (coarse_cand > 127 || coarse_cand < -128) overflow_sticky = 1'b1;
            if (fine_cand > 127 || fine_cand < -128) finer_sticky = 1'b0;
            if (coarse_cand > 127) begin
                coarse_cand = 127;
            end else if (coarse_cand < -128) begin
                coarse_cand = -128;
            end
            res.quant    = coarse_cand[7:0];
            res.overflow = overflow_sticky;
            res.finer    = finer_sticky;
            return res;
        endfunction

        function void note_input(logic [GRAD_W-1:0] grad, bit restart);
            quant_q.push_back(requantize(grad, restart));
        endfunction

        function void report_field(string field, int want, int got);
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] flags);
            quant_result_t want;
            if (quant_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result 0x%02h / %b arrived with nothing expected", data, flags);
                return;
            end
            want = quant_q.pop_front();
            if (data !== want.quant)
                report_field("quant_value", $signed(want.quant), $signed(data));
            if (flags[0] !== want.overflow)
                report_field("overflow_seen", want.overflow, flags[0]);
            if (flags[1] !== want.finer)
                report_field("fits_finer", want.finer, flags[1]);
        endfunction

        function int pending();
            return quant_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;     // [31:0] grad_value
    logic [0:0]           s_tuser = '0;     // [0] restart_flags
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;          // [7:0] quant_value
    logic [1:0]           m_tuser;          // [0] overflow_seen, [1] fits_finer
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    bit                   rx_random = 1'b0;
    requant_scoreboard    board = new();

    int8_requantize_stochastic_round_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offer one item and hold it until it is taken; valid stays high afterward.
    task automatic send_item(input logic [31:0] grad, input bit restart);
        s_tvalid <= 1'b1;
        s_tdata  <= grad;
        s_tuser  <= restart;
        do @(posedge i_clk); while (!s_tready);
        board.note_input(grad, restart);
    endtask

    // Write one register; the caller lowers the valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.apply_config(idx, data);
    endtask

    // Stop sending and wait until every result is back and the pipe is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] src, input logic [7:0] tgt,
                                input logic [7:0] seed);
        drain();
        write_reg(CFG_SOURCE_SCALE, src);
        write_reg(CFG_TARGET_SCALE, tgt);
        write_reg(CFG_LFSR_SEED, seed);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender gap: often none, mostly short, now and then long.
    task automatic idle_gap();
        int len;
        if ($urandom_range(0, 2) != 0) return;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        s_tvalid <= 1'b0;
        repeat (len) @(posedge i_clk);
    endtask

    // Arithmetic shifts of a random word spread magnitudes over every octave.
    function automatic logic [31:0] random_grad();
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 3) == 0) return raw;
        return $signed(raw) >>> $urandom_range(0, 31);
    endfunction

    task automatic run_phase(input logic [7:0] src, input logic [7:0] tgt,
                             input logic [7:0] seed, input bit tx_gaps,
                             input bit pause_mid);
        program_regs(src, tgt, seed);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (pause_mid && n == PHASE_ITEMS / 2) begin
                drain();
            end else if (tx_gaps) begin
                idle_gap();
            end
            send_item(random_grad(), $urandom_range(0, 15) == 0);
        end
    endtask

    // Result side: checks every taken item, with random back-pressure if rx_random.
    // Twice it holds off for a long stretch so the block fills and stalls.
    initial begin : result_sink
        int stall_left;
        int taken;
        stall_left = 0;
        taken = 0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata, m_tuser);
                taken++;
                if (taken == 600 || taken == 1400) stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (rx_random && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Watchdog: ends the run after too many cycles without any handshake.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] corner_vals[10];
        corner_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd127, 32'hFFFF_FF80,
                        32'd128, 32'hFFFF_FF7F, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h0000_0055};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: extremes and saturation, restarting the flags twice.
        rx_random = 1'b1;
        for (int n = 0; n < 10; n++) send_item(corner_vals[n], n == 4 || n == 9);

        // Zero seed locks the LFSR: any nonzero dropped byte rounds up.
        program_regs(8'd9, 8'd0, 8'd0);
        send_item(32'd1, 1'b0);
        send_item(32'h0000_0100, 1'b0);
        send_item(32'h0000_01FF, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);

        // A left shift of 32 or more clears the value entirely.
        program_regs(8'd0, 8'd23, 8'hFF);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);

        // Writes beyond the register list are dropped; wide data is truncated.
        drain();
        write_reg(CFG_UNUSED, 8'hC7);
        write_reg(CFG_SOURCE_SCALE, 8'hFF);
        write_reg(CFG_TARGET_SCALE, 8'hE4);
        i_cfg_valid <= 1'b0;
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h1234_5678, 1'b0);

        // Random phases over a spread of scales and seeds.
        for (int p = 0; p < 10; p++) begin
            logic [7:0] src;
            logic [7:0] tgt;
            logic [7:0] seed;
            case (p)
                0: begin src = 8'd0;  tgt = 8'd0;  seed = 8'h01; end
                1: begin src = 8'd31; tgt = 8'd0;  seed = 8'hFF; end
                2: begin src = 8'd0;  tgt = 8'd31; seed = 8'h80; end
                3: begin src = 8'd31; tgt = 8'd31; seed = 8'hA5; end
                4: begin src = 8'd16; tgt = 8'd8;  seed = 8'h00; end
                5: begin src = 8'd20; tgt = 8'd0;  seed = 8'h3C; end
                6: begin src = 8'd0;  tgt = 8'd22; seed = 8'h01; end
                7: begin src = 8'd9;  tgt = 8'd0;  seed = 8'h5A; end
                8: begin src = 8'd4;  tgt = 8'd2;  seed = 8'hC3; end
                default: begin src = 8'd12; tgt = 8'd3; seed = 8'hFE; end
            endcase
            rx_random = (p % 3 != 0);
            run_phase(src, tgt, seed, p % 3 != 0, p % 2 == 1);
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

### int8_requantize_stochastic_round_unit.f
+incdir+hw/rtl
hw/rtl/irsr_pkg.sv
hw/rtl/irsr_shift.sv
hw/rtl/irsr_round.sv
hw/rtl/int8_requantize_stochastic_round_unit.sv
hw/rtl/irsr_chk.sv
tb/testbench.sv
